// ----- rtl/rdvc_pkg.sv -----
package rdvc_pkg;

	// field widths of the transfer payloads
	localparam int LEN_W   = 11;
	localparam int VAL_W   = 12;
	localparam int RIGHT_W = 11;
	localparam int TAG_W   = 16;
	localparam int COUNT_W = 11;

	// array length after reset, before clamping
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// request operations
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// kinds of tree walk
	typedef enum logic [1:0] {
		WM_ADD = 2'd0,
		WM_SUB = 2'd1,
		WM_SUM = 2'd2
	} walk_mode_t;

	// tree walker states
	typedef enum logic {
		FW_IDLE = 1'b0,
		FW_RUN  = 1'b1
	} fw_state_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR    = 3'd0,
		ST_IDLE     = 3'd1,
		ST_LS_READ  = 3'd2,
		ST_LS_WRITE = 3'd3,
		ST_ADD      = 3'd4,
		ST_SUB      = 3'd5,
		ST_SUM_R    = 3'd6,
		ST_SUM_L    = 3'd7
	} top_state_t;

	// command from controller to tree walker
	typedef struct packed {
		logic       go;
		logic       clr;
		walk_mode_t mode;
	} fw_cmd_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [VAL_W-1:0]   element_value;
		logic [RIGHT_W-1:0] right_end;
		logic [TAG_W-1:0]   query_tag;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]   result_tag;
		logic [COUNT_W-1:0] distinct_count;
		logic               range_error;
	} out_item_t;

endpackage

// ----- rtl/rdvc_ram.sv -----
module rdvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rdvc_fenwick.sv -----
module rdvc_fenwick #(
	parameter int POSITIONS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rdvc_pkg::fw_cmd_t                   cmd,
	input  logic [$clog2(POSITIONS+1)-1:0]      pos,
	input  logic [$clog2(POSITIONS+1)-1:0]      len,
	output logic [$clog2(POSITIONS+1)-1:0]      sum,
	output logic                                done
);

	localparam int PW = $clog2(POSITIONS + 1);

	rdvc_pkg::fw_state_t  state_q;
	rdvc_pkg::walk_mode_t mode_q;
	logic [PW:0]          p_q;
	logic [PW:0]          lowbit;
	logic [PW:0]          next_p;
	logic                 in_range;
	logic                 issue;
	logic                 v_s1;
	logic [PW-1:0]        a_s1;
	logic [PW-1:0]        sum_q;
	logic                 done_q;
	logic                 ram_we;
	logic [PW-1:0]        ram_waddr;
	logic [PW-1:0]        ram_wdata;
	logic [PW-1:0]        ram_rdata;

	// next tree index: up for updates, down for prefix sums
	always_comb begin
		lowbit   = p_q & (~p_q + (PW+1)'(1));
		next_p   = (mode_q == rdvc_pkg::WM_SUM) ? (p_q - lowbit) : (p_q + lowbit);
		in_range = (mode_q == rdvc_pkg::WM_SUM) ? (p_q != '0) : (p_q <= {1'b0, len});
		issue    = (state_q == rdvc_pkg::FW_RUN) && in_range;
	end

	// write back the node read in the cycle before, or clear sweep
	always_comb begin
		ram_we    = cmd.clr || (v_s1 && (mode_q != rdvc_pkg::WM_SUM));
		ram_waddr = cmd.clr ? pos : a_s1;
		if (cmd.clr) begin
			ram_wdata = '0;
		end else if (mode_q == rdvc_pkg::WM_ADD) begin
			ram_wdata = ram_rdata + PW'(1);
		end else begin
			ram_wdata = ram_rdata - PW'(1);
		end
	end

	rdvc_ram #(
		.WIDTH(PW),
		.DEPTH(POSITIONS + 1)
	) u_tree (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(p_q[PW-1:0]),
		.rdata(ram_rdata)
	);

	// walk sequencer: one node read per cycle, each write in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdvc_pkg::FW_IDLE;
			mode_q  <= rdvc_pkg::WM_SUM;
			p_q     <= '0;
			v_s1    <= 1'b0;
			a_s1    <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				rdvc_pkg::FW_IDLE: begin
					v_s1 <= 1'b0;
					if (cmd.go) begin
						p_q     <= {1'b0, pos};
						mode_q  <= cmd.mode;
						sum_q   <= '0;
						state_q <= rdvc_pkg::FW_RUN;
					end
				end
				rdvc_pkg::FW_RUN: begin
					v_s1 <= issue;
					a_s1 <= p_q[PW-1:0];
					if (v_s1 && (mode_q == rdvc_pkg::WM_SUM)) begin
						sum_q <= sum_q + ram_rdata;
					end
					if (issue) begin
						p_q <= next_p;
					end else begin
						state_q <= rdvc_pkg::FW_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= rdvc_pkg::FW_IDLE;
				end
			endcase
		end
	end

	assign sum  = sum_q;
	assign done = done_q;

endmodule

// ----- rtl/range_distinct_value_count.sv -----
// channel  | ports                     | transfer
// ---------+---------------------------+---------------------------------------
// config   | cfg_we, cfg_wdata         | array_length, any edge with cfg_we
// request  | start, busy, request      | edge with start high and busy low
// result   | done, result              | one cycle, edge that ends done high
//
// A load holds busy through a last-seen read and write, its add walk and, if the value was
// seen before, a subtract walk; a query through its two prefix-sum walks.
// Walks run at one node per cycle, set by the single tree read port. Other requests
// leave busy low; a bad query answers the next cycle, a good one as busy drops.
// Reset, a clear request or a config write sweeps both memories over
// max(POSITIONS+1, 2**VALUE_BITS) addresses (4096 at default sizes), busy high; no result stall.
module range_distinct_value_count #(
	parameter int POSITIONS  = 1024,
	parameter int VALUE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rdvc_pkg::LEN_W-1:0]      cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  rdvc_pkg::in_item_t              request,
	output logic                            done,
	output rdvc_pkg::out_item_t             result
);

	localparam int PW        = $clog2(POSITIONS + 1);
	localparam int VW        = VALUE_BITS;
	localparam int CW        = (PW > rdvc_pkg::LEN_W) ? PW : rdvc_pkg::LEN_W;
	localparam int CLR_DEPTH = ((POSITIONS + 1) > (2 ** VW)) ? (POSITIONS + 1) : (2 ** VW);
	localparam int CLW       = $clog2(CLR_DEPTH);

	// clamp a written length into 1..POSITIONS
	function automatic logic [PW-1:0] clamp_len(input logic [rdvc_pkg::LEN_W-1:0] v);
		logic [PW-1:0] r;
		if (v == '0) begin
			r = PW'(1);
		end else if (CW'(v) > CW'(POSITIONS)) begin
			r = PW'(POSITIONS);
		end else begin
			r = PW'(v);
		end
		return r;
	endfunction

	rdvc_pkg::top_state_t state_q;
	rdvc_pkg::top_state_t state_d;
	logic [CLW-1:0]       clr_q;
	logic [PW-1:0]        len_q;
	logic [PW-1:0]        cur_q;
	logic [PW-1:0]        pos_q;
	logic [VW-1:0]        val_q;
	logic [PW-1:0]        later_q;
	logic [PW-1:0]        sumr_q;
	logic [rdvc_pkg::TAG_W-1:0] tag_q;
	logic                 done_q;
	rdvc_pkg::out_item_t  result_q;
	logic                 accept;
	logic                 bad;
	logic [PW-1:0]        cfg_len;

	rdvc_pkg::fw_cmd_t    fw_cmd;
	logic [PW-1:0]        fw_pos;
	logic [PW-1:0]        fw_sum;
	logic                 fw_done;

	logic                 ls_we;
	logic [VW-1:0]        ls_waddr;
	logic [PW-1:0]        ls_wdata;
	logic [PW-1:0]        ls_rdata;

	assign accept  = start && (state_q == rdvc_pkg::ST_IDLE);
	assign cfg_len = clamp_len(cfg_wdata);

	// query check: nothing loaded, or right end outside [current, length]
	assign bad = (cur_q > len_q) ||
	             (CW'(request.right_end) > CW'(len_q)) ||
	             (CW'(request.right_end) < CW'(cur_q));

	// last-seen table: cleared by the sweep, updated once per load that has room
	always_comb begin
		ls_we    = (state_q == rdvc_pkg::ST_CLEAR) || (state_q == rdvc_pkg::ST_LS_WRITE);
		ls_waddr = (state_q == rdvc_pkg::ST_CLEAR) ? VW'(clr_q) : val_q;
		ls_wdata = (state_q == rdvc_pkg::ST_CLEAR) ? '0 : pos_q;
	end

	rdvc_ram #(
		.WIDTH(PW),
		.DEPTH(2 ** VW)
	) u_last_seen (
		.clk  (clk),
		.we   (ls_we),
		.waddr(ls_waddr),
		.wdata(ls_wdata),
		.raddr(val_q),
		.rdata(ls_rdata)
	);

	rdvc_fenwick #(
		.POSITIONS(POSITIONS)
	) u_fenwick (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (fw_cmd),
		.pos   (fw_pos),
		.len   (len_q),
		.sum   (fw_sum),
		.done  (fw_done)
	);

	// next state and walker commands
	always_comb begin
		state_d     = state_q;
		fw_cmd.go   = 1'b0;
		fw_cmd.clr  = 1'b0;
		fw_cmd.mode = rdvc_pkg::WM_SUM;
		fw_pos      = pos_q;
		case (state_q)
			rdvc_pkg::ST_CLEAR: begin
				fw_cmd.clr = (clr_q <= CLW'(POSITIONS));
				fw_pos     = PW'(clr_q);
				if (clr_q == CLW'(CLR_DEPTH - 1)) begin
					state_d = rdvc_pkg::ST_IDLE;
				end
			end
			rdvc_pkg::ST_IDLE: begin
				if (start) begin
					case (request.operation)
						rdvc_pkg::OP_LOAD: begin
							if (cur_q > PW'(1)) begin
								state_d = rdvc_pkg::ST_LS_READ;
							end
						end
						rdvc_pkg::OP_QUERY: begin
							if (!bad) begin
								fw_cmd.go = 1'b1;
								fw_pos    = PW'(request.right_end);
								state_d   = rdvc_pkg::ST_SUM_R;
							end
						end
						rdvc_pkg::OP_CLEAR: begin
							state_d = rdvc_pkg::ST_CLEAR;
						end
						default: begin
							state_d = rdvc_pkg::ST_IDLE;
						end
					endcase
				end
			end
			rdvc_pkg::ST_LS_READ: begin
				state_d = rdvc_pkg::ST_LS_WRITE;
			end
			rdvc_pkg::ST_LS_WRITE: begin
				fw_cmd.go   = 1'b1;
				fw_cmd.mode = rdvc_pkg::WM_ADD;
				state_d     = rdvc_pkg::ST_ADD;
			end
			rdvc_pkg::ST_ADD: begin
				if (fw_done) begin
					if (later_q != '0) begin
						fw_cmd.go   = 1'b1;
						fw_cmd.mode = rdvc_pkg::WM_SUB;
						fw_pos      = later_q;
						state_d     = rdvc_pkg::ST_SUB;
					end else begin
						state_d = rdvc_pkg::ST_IDLE;
					end
				end
			end
			rdvc_pkg::ST_SUB: begin
				if (fw_done) begin
					state_d = rdvc_pkg::ST_IDLE;
				end
			end
			rdvc_pkg::ST_SUM_R: begin
				if (fw_done) begin
					fw_cmd.go = 1'b1;
					fw_pos    = cur_q - PW'(1);
					state_d   = rdvc_pkg::ST_SUM_L;
				end
			end
			rdvc_pkg::ST_SUM_L: begin
				if (fw_done) begin
					state_d = rdvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdvc_pkg::ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = rdvc_pkg::ST_CLEAR;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdvc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// position bookkeeping, sweep counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			len_q    <= clamp_len(rdvc_pkg::LEN_RESET);
			cur_q    <= clamp_len(rdvc_pkg::LEN_RESET) + PW'(1);
			pos_q    <= '0;
			val_q    <= '0;
			later_q  <= '0;
			sumr_q   <= '0;
			tag_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				len_q <= cfg_len;
				cur_q <= cfg_len + PW'(1);
				clr_q <= '0;
			end else begin
				case (state_q)
					rdvc_pkg::ST_CLEAR: begin
						clr_q <= clr_q + CLW'(1);
					end
					rdvc_pkg::ST_IDLE: begin
						if (accept) begin
							case (request.operation)
								rdvc_pkg::OP_LOAD: begin
									if (cur_q > PW'(1)) begin
										cur_q <= cur_q - PW'(1);
										pos_q <= cur_q - PW'(1);
										val_q <= VW'(request.element_value);
									end
								end
								rdvc_pkg::OP_QUERY: begin
									tag_q <= request.query_tag;
									if (bad) begin
										done_q                  <= 1'b1;
										result_q.result_tag     <= request.query_tag;
										result_q.distinct_count <= '0;
										result_q.range_error    <= 1'b1;
									end
								end
								rdvc_pkg::OP_CLEAR: begin
									cur_q <= len_q + PW'(1);
									clr_q <= '0;
								end
								default: begin
									clr_q <= clr_q;
								end
							endcase
						end
					end
					rdvc_pkg::ST_LS_WRITE: begin
						later_q <= ls_rdata;
					end
					rdvc_pkg::ST_SUM_R: begin
						if (fw_done) begin
							sumr_q <= fw_sum;
						end
					end
					rdvc_pkg::ST_SUM_L: begin
						if (fw_done) begin
							done_q                  <= 1'b1;
							result_q.result_tag     <= tag_q;
							result_q.distinct_count <= rdvc_pkg::COUNT_W'(sumr_q - fw_sum);
							result_q.range_error    <= 1'b0;
						end
					end
					default: begin
						clr_q <= clr_q;
					end
				endcase
			end
		end
	end

	assign busy   = (state_q != rdvc_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
